FILE: hdl/imd_pkg.sv
// Shared constants, types and item tables for the IMU data message deframer.
package imd_pkg;

  localparam logic [7:0] PREAMBLE = 8'hFA;

  localparam logic [7:0] RESET_MSG_ID = 8'h36;
  localparam logic [7:0] RESET_BUS_ID = 8'hFF;

  // Configuration register indexes
  localparam logic [7:0] REG_MSG_ID = 8'd0;
  localparam logic [7:0] REG_BUS_ID = 8'd1;

  // Result kinds
  localparam logic [1:0] RES_ELEMENT = 2'd0;
  localparam logic [1:0] RES_SUM_OK  = 2'd1;
  localparam logic [1:0] RES_SUM_BAD = 2'd2;

  // Quantity codes
  localparam logic [3:0] Q_DCM      = 4'd0;
  localparam logic [3:0] Q_ACCEL    = 4'd1;
  localparam logic [3:0] Q_RATE     = 4'd2;
  localparam logic [3:0] Q_VELOCITY = 4'd3;
  localparam logic [3:0] Q_ALTITUDE = 4'd4;
  localparam logic [3:0] Q_LATLON   = 4'd5;
  localparam logic [3:0] Q_PRESSURE = 4'd6;
  localparam logic [3:0] Q_TEMP     = 4'd7;
  localparam logic [3:0] Q_FIX      = 4'd8;
  localparam logic [3:0] Q_SATS     = 4'd9;
  localparam logic [3:0] Q_DOP      = 4'd10;
  // The gps item shares its code with the fix quantity; it is split by offset.
  localparam logic [3:0] Q_GPS_ITEM = 4'd8;

  // Gps item byte offsets
  localparam logic [7:0] GPS_FIX_POS   = 8'd20;
  localparam logic [7:0] GPS_SATS_POS  = 8'd22;
  localparam logic [7:0] GPS_DOP_FIRST = 8'd81;
  localparam logic [7:0] GPS_DOP_LAST  = 8'd89;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  quantity;
    logic [3:0]  element_index;
    logic [63:0] element_value;
    logic [3:0]  element_bytes;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [3:0] quantity;
  } item_id_t;

  // Map a two-byte item id to its quantity.
  function automatic item_id_t lookup_item(input logic [7:0] hi, input logic [7:0] lo);
    item_id_t r;
    r.known    = 1'b1;
    r.quantity = Q_DCM;
    if      (hi == 8'h20 && lo == 8'h20) r.quantity = Q_DCM;
    else if (hi == 8'h40 && lo == 8'h20) r.quantity = Q_ACCEL;
    else if (hi == 8'h80 && lo == 8'h20) r.quantity = Q_RATE;
    else if (hi == 8'hD0 && lo == 8'h13) r.quantity = Q_VELOCITY;
    else if (hi == 8'h50 && lo == 8'h23) r.quantity = Q_ALTITUDE;
    else if (hi == 8'h50 && lo == 8'h43) r.quantity = Q_LATLON;
    else if (hi == 8'h30 && lo == 8'h10) r.quantity = Q_PRESSURE;
    else if (hi == 8'h08 && lo == 8'h10) r.quantity = Q_TEMP;
    else if (hi == 8'h70 && lo == 8'h10) r.quantity = Q_GPS_ITEM;
    else begin
      r.known    = 1'b0;
      r.quantity = Q_DCM;
    end
    return r;
  endfunction

  // Whether a plain quantity's elements are 8-byte doubles rather than 4 bytes wide.
  function automatic logic is_double(input logic [2:0] q);
    return (q == Q_VELOCITY[2:0]) || (q == Q_ALTITUDE[2:0]) || (q == Q_LATLON[2:0]);
  endfunction

  // Number of elements that a plain quantity reports.
  function automatic logic [3:0] element_limit(input logic [2:0] q);
    logic [3:0] r;
    case (q)
      3'd0:    r = 4'd9;
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd3;
      3'd3:    r = 4'd3;
      3'd4:    r = 4'd1;
      3'd5:    r = 4'd2;
      3'd6:    r = 4'd1;
      3'd7:    r = 4'd1;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/imd_rx_if.sv
// Byte input channel of the deframer.
interface imd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/imd_res_if.sv
// Result channel of the deframer.
interface imd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  quantity;
  logic [3:0]  element_index;
  logic [63:0] element_value;
  logic [3:0]  element_bytes;

  modport source (output valid, output result_kind, output quantity, output element_index,
                  output element_value, output element_bytes, input ready);
  modport sink   (input valid, input result_kind, input quantity, input element_index,
                  input element_value, input element_bytes, output ready);
endinterface

FILE: hdl/imd_cfg_if.sv
// Configuration write channel of the deframer.
interface imd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/imu_data_message_deframer.sv
// Byte-serial deframer for inertial data messages: top level.
//
// rx_i takes one received byte per beat. The parser hunts for the preamble,
// checks bus id and message id (cfg_i registers 0: message id, 1: bus id),
// reads the frame length and walks the data items. Each completed element of a
// known item, within its quantity's element limit, leaves on res_o as one beat;
// the checksum byte of a frame gives one beat with the checksum verdict. Unknown
// items are skipped by length. Each result is registered in the result buffer.
// Throughput: one byte per cycle while rx_i.ready is high; the parser state
// updates in the accepting cycle, so the state loop of one byte sets the rate.
// The result side has a two-entry buffer: with res_o stalled, bytes keep
// being accepted until a second result is waiting, then rx_i.ready drops.
// Bytes that yield no result still need a free second entry.
// Reset returns to the preamble hunt with message id 0x36 and bus id 0xFF,
// and empties the result buffer. cfg_i is always ready; write it while idle.
module imu_data_message_deframer (
  input  logic clk_i,
  input  logic rst_ni,
  imd_rx_if.sink    rx_i,
  imd_cfg_if.sink   cfg_i,
  imd_res_if.source res_o
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_BUSID, PH_MSGID, PH_LENGTH, PH_ID_HI, PH_ID_LO, PH_ITEMLEN, PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  msg_id_q, bus_id_q;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  frame_seen_q, frame_seen_d;
  logic [7:0]  first_id_q, first_id_d;
  logic [3:0]  item_q_q, item_q_d;
  logic        item_known_q, item_known_d;
  logic [7:0]  item_len_q, item_len_d;
  logic [7:0]  item_pos_q, item_pos_d;
  logic [63:0] shift_q, shift_d;
  logic [3:0]  elem_cnt_q, elem_cnt_d;

  imd_pkg::result_t head_q, skid_q, res_new;
  logic             head_v_q, skid_v_q;
  logic             emit;

  logic       rx_fire, res_fire;
  logic [7:0] b;
  logic [7:0] sum_b;
  logic [7:0] pos_next;
  logic [63:0] shift_next;
  logic        dbl;
  logic        elem_done;
  logic [7:0]  dop_off;
  imd_pkg::item_id_t id_lu;

  assign rx_fire  = rx_i.valid && rx_i.ready;
  assign res_fire = res_o.valid && res_o.ready;
  assign b        = rx_i.rx_byte;
  assign sum_b    = sum_q + b;
  assign pos_next = item_pos_q + 8'd1;
  assign shift_next = {shift_q[55:0], b};
  assign dbl      = imd_pkg::is_double(item_q_q[2:0]);
  assign elem_done = dbl ? (pos_next[2:0] == 3'd0) : (pos_next[1:0] == 2'd0);
  assign dop_off  = item_pos_q - imd_pkg::GPS_DOP_FIRST;
  assign id_lu    = imd_pkg::lookup_item(first_id_q, b);

  assign rx_i.ready  = !skid_v_q;
  assign cfg_i.ready = 1'b1;

  // Parser next state for one accepted byte
  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    frame_len_d  = frame_len_q;
    frame_seen_d = frame_seen_q;
    first_id_d   = first_id_q;
    item_q_d     = item_q_q;
    item_known_d = item_known_q;
    item_len_d   = item_len_q;
    item_pos_d   = item_pos_q;
    shift_d      = shift_q;
    elem_cnt_d   = elem_cnt_q;
    emit         = 1'b0;
    res_new      = '0;
    res_new.result_kind = imd_pkg::RES_ELEMENT;

    case (phase_q)
      PH_HUNT: begin
        if (b == imd_pkg::PREAMBLE) begin
          phase_d = PH_BUSID;
          sum_d   = 8'd0;
        end
      end
      PH_BUSID: begin
        if (b == bus_id_q) begin
          phase_d = PH_MSGID;
          sum_d   = b;
        end else if (b == imd_pkg::PREAMBLE) begin
          sum_d = 8'd0;
        end else begin
          phase_d = PH_HUNT;
          sum_d   = 8'd0;
        end
      end
      PH_MSGID: begin
        if (b == msg_id_q) begin
          phase_d = PH_LENGTH;
          sum_d   = sum_b;
        end else begin
          phase_d = PH_HUNT;
          sum_d   = 8'd0;
        end
      end
      PH_LENGTH: begin
        frame_len_d  = b;
        sum_d        = sum_b;
        frame_seen_d = 8'd0;
        phase_d      = PH_ID_HI;
      end
      default: begin
        sum_d = sum_b;
        if (frame_seen_q >= frame_len_q) begin
          // Checksum byte: report the verdict and drop any open item
          emit    = 1'b1;
          phase_d = PH_HUNT;
          res_new.result_kind = (sum_b == 8'd0) ? imd_pkg::RES_SUM_OK
                                                : imd_pkg::RES_SUM_BAD;
        end else begin
          frame_seen_d = frame_seen_q + 8'd1;
          case (phase_q)
            PH_ID_HI: begin
              first_id_d = b;
              phase_d    = PH_ID_LO;
            end
            PH_ID_LO: begin
              item_known_d = id_lu.known;
              item_q_d     = id_lu.quantity;
              phase_d      = PH_ITEMLEN;
            end
            PH_ITEMLEN: begin
              item_len_d = b;
              item_pos_d = 8'd0;
              shift_d    = '0;
              elem_cnt_d = 4'd0;
              phase_d    = (b != 8'd0) ? PH_DATA : PH_ID_HI;
            end
            default: begin
              shift_d    = shift_next;
              item_pos_d = pos_next;
              if (item_known_q) begin
                if (item_q_q != imd_pkg::Q_GPS_ITEM) begin
                  if (elem_done && elem_cnt_q < imd_pkg::element_limit(item_q_q[2:0])) begin
                    emit                  = 1'b1;
                    res_new.quantity      = item_q_q;
                    res_new.element_index = elem_cnt_q;
                    res_new.element_value = dbl ? shift_next : {32'd0, shift_next[31:0]};
                    res_new.element_bytes = dbl ? 4'd8 : 4'd4;
                    elem_cnt_d            = elem_cnt_q + 4'd1;
                  end
                end else if (item_pos_q == imd_pkg::GPS_FIX_POS) begin
                  emit                  = 1'b1;
                  res_new.quantity      = imd_pkg::Q_FIX;
                  res_new.element_value = {56'd0, b};
                  res_new.element_bytes = 4'd1;
                end else if (item_pos_q == imd_pkg::GPS_SATS_POS) begin
                  emit                  = 1'b1;
                  res_new.quantity      = imd_pkg::Q_SATS;
                  res_new.element_value = {56'd0, b};
                  res_new.element_bytes = 4'd1;
                end else if (item_pos_q >= imd_pkg::GPS_DOP_FIRST &&
                             item_pos_q <= imd_pkg::GPS_DOP_LAST && item_pos_q[0]) begin
                  emit                  = 1'b1;
                  res_new.quantity      = imd_pkg::Q_DOP;
                  res_new.element_index = dop_off[4:1];
                  res_new.element_value = {48'd0, shift_next[15:0]};
                  res_new.element_bytes = 4'd2;
                end
              end
              if (pos_next == item_len_q) phase_d = PH_ID_HI;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      msg_id_q     <= imd_pkg::RESET_MSG_ID;
      bus_id_q     <= imd_pkg::RESET_BUS_ID;
      sum_q        <= 8'd0;
      frame_len_q  <= 8'd0;
      frame_seen_q <= 8'd0;
      first_id_q   <= 8'd0;
      item_q_q     <= 4'd0;
      item_known_q <= 1'b0;
      item_len_q   <= 8'd0;
      item_pos_q   <= 8'd0;
      shift_q      <= '0;
      elem_cnt_q   <= 4'd0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == imd_pkg::REG_MSG_ID) msg_id_q <= cfg_i.data;
        if (cfg_i.index == imd_pkg::REG_BUS_ID) bus_id_q <= cfg_i.data;
      end
      if (rx_fire) begin
        phase_q      <= phase_d;
        sum_q        <= sum_d;
        frame_len_q  <= frame_len_d;
        frame_seen_q <= frame_seen_d;
        first_id_q   <= first_id_d;
        item_q_q     <= item_q_d;
        item_known_q <= item_known_d;
        item_len_q   <= item_len_d;
        item_pos_q   <= item_pos_d;
        shift_q      <= shift_d;
        elem_cnt_q   <= elem_cnt_d;
      end
    end
  end

  // Two-entry result buffer: head drives the port, skid catches a beat while stalled
  logic push;
  assign push = rx_fire && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!head_v_q || res_fire) begin
      if (skid_v_q) begin
        head_v_q <= 1'b1;
        skid_v_q <= push;
      end else begin
        head_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_v_q || res_fire) begin
      if (skid_v_q) begin
        head_q <= skid_q;
        if (push) skid_q <= res_new;
      end else if (push) begin
        head_q <= res_new;
      end
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid         = head_v_q;
  assign res_o.result_kind   = head_q.result_kind;
  assign res_o.quantity      = head_q.quantity;
  assign res_o.element_index = head_q.element_index;
  assign res_o.element_value = head_q.element_value;
  assign res_o.element_bytes = head_q.element_bytes;

  // Skid entry is only ever filled behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q) else $error("skid entry valid without head entry");

  // A stalled head with a new result must land in the skid entry
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && head_v_q && !res_fire && !skid_v_q) |=> (skid_v_q && head_v_q))
    else $error("result lost while output stalled");

  // Inside a frame body the byte count never passes the frame length
  a_frame_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ID_HI || phase_q == PH_ID_LO || phase_q == PH_ITEMLEN ||
     phase_q == PH_DATA) |-> (frame_seen_q <= frame_len_q))
    else $error("frame byte count beyond frame length");

  // An open item always has bytes left
  a_item_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (item_pos_q < item_len_q))
    else $error("item position reached item length in data phase");

  // Element count of a plain quantity stays within its table limit
  a_elem_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA && item_known_q && item_q_q != imd_pkg::Q_GPS_ITEM) |->
    (elem_cnt_q <= imd_pkg::element_limit(item_q_q[2:0])))
    else $error("element count beyond quantity limit");

endmodule
